@@ rtl/tpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpsc_pkg
// Types and constants shared by the two-point sensor calibration unit.
// ----------------------------------------------------------------------------
package tpsc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned DenW    = 16;   // divisor magnitude
  localparam int unsigned NumW    = 30;   // dividend magnitude, also quotient
  localparam int unsigned NumCells = NumW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HUM_LOW_REF   = 8'd0,
    REG_HUM_HIGH_REF  = 8'd1,
    REG_TEMP_LOW_REF  = 8'd2,
    REG_TEMP_HIGH_REF = 8'd3,
    REG_HUM_LOW_RAW   = 8'd4,
    REG_HUM_HIGH_RAW  = 8'd5,
    REG_TEMP_LOW_RAW  = 8'd6,
    REG_TEMP_HIGH_RAW = 8'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EQUAL = 2'd1,
    STATUS_SAT   = 2'd2
  } status_e;

  typedef enum logic {
    MODE_HUM  = 1'b0,
    MODE_TEMP = 1'b1
  } mode_e;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         hum_low_ref;
    logic [7:0]         hum_high_ref;
    logic [9:0]         temp_low_ref;
    logic [9:0]         temp_high_ref;
    logic signed [15:0] hum_low_raw;
    logic signed [15:0] hum_high_raw;
    logic signed [15:0] temp_low_raw;
    logic signed [15:0] temp_high_raw;
  } cal_regs_t;

  // Data carried along the divider chain
  typedef struct packed {
    logic [DenW-1:0] rem;     // partial remainder
    logic [NumW-1:0] quo;     // dividend bits shifting out, quotient bits in
    logic [DenW-1:0] den;     // divisor magnitude
    logic            neg;     // result sign
    logic            err;     // reference raws equal
  } div_item_t;

endpackage

@@ rtl/tpsc_front.sv @@
// ----------------------------------------------------------------------------
// tpsc_front
// Selects the calibration points, forms the two products, then the scaled
// numerator and the magnitudes that enter the divider chain.
// ----------------------------------------------------------------------------
module tpsc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tpsc_pkg::in_item_t   item_i,
  input  tpsc_pkg::cal_regs_t  regs_i,
  output logic                 valid_o,
  output tpsc_pkg::div_item_t  item_o
);
  import tpsc_pkg::*;

  // stage 1: products
  logic signed [10:0] y0_s, y1_s, dy_s;
  logic signed [16:0] x0_s, x1_s, den_s, dx_s;

  logic               s1_valid_q;
  logic signed [27:0] p1_q, p2_q, p1_d, p2_d;
  logic signed [16:0] den_q;
  logic               temp_q, err_q;

  always_comb begin
    if (item_i.mode == MODE_TEMP) begin
      y0_s = $signed({1'b0, regs_i.temp_low_ref});
      y1_s = $signed({1'b0, regs_i.temp_high_ref});
      x0_s = 17'(regs_i.temp_low_raw);
      x1_s = 17'(regs_i.temp_high_raw);
    end else begin
      y0_s = $signed({3'b000, regs_i.hum_low_ref});
      y1_s = $signed({3'b000, regs_i.hum_high_ref});
      x0_s = 17'(regs_i.hum_low_raw);
      x1_s = 17'(regs_i.hum_high_raw);
    end
    den_s = x1_s - x0_s;
    dx_s  = 17'(item_i.raw_sample) - x0_s;
    dy_s  = y1_s - y0_s;
    p1_d  = 28'(y0_s) * 28'(den_s);
    p2_d  = 28'(dx_s) * 28'(dy_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      den_q  <= den_s;
      temp_q <= (item_i.mode == MODE_TEMP);
      err_q  <= (den_s == 17'sd0);
    end
  end

  // stage 2: scaled numerator and magnitudes
  logic signed [28:0] sum_s;
  logic signed [31:0] num_s, num_abs;
  logic signed [16:0] den_abs;
  logic               s2_valid_q;
  div_item_t          s2_d, s2_q;

  always_comb begin
    sum_s   = 29'(p1_q) + 29'(p2_q);
    num_s   = temp_q ? (32'(sum_s) <<< 1) : (32'(sum_s) <<< 3);
    num_abs = num_s[31] ? -num_s : num_s;
    den_abs = den_q[16] ? -den_q : den_q;
    s2_d.rem = '0;
    s2_d.quo = num_abs[NumW-1:0];
    s2_d.den = den_abs[DenW-1:0];
    s2_d.neg = num_s[31] ^ den_q[16];
    s2_d.err = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign item_o  = s2_q;

endmodule

@@ rtl/tpsc_div_cell.sv @@
// ----------------------------------------------------------------------------
// tpsc_div_cell
// One restoring division step: retires one quotient bit and passes the
// partial remainder and quotient on to the next cell.
// ----------------------------------------------------------------------------
module tpsc_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tpsc_pkg::div_item_t  item_i,
  output logic                 valid_o,
  output tpsc_pkg::div_item_t  item_o
);
  import tpsc_pkg::*;

  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;
  logic            fits;
  div_item_t       item_d, item_q;
  logic            valid_q;

  always_comb begin
    trial  = {item_i.rem, item_i.quo[NumW-1]};
    diff   = {1'b0, trial} - {2'b00, item_i.den};
    fits   = ~diff[DenW+1];
    item_d = item_i;
    item_d.rem = fits ? diff[DenW-1:0] : trial[DenW-1:0];
    item_d.quo = {item_i.quo[NumW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/tpsc_out.sv @@
// ----------------------------------------------------------------------------
// tpsc_out
// Applies sign and saturation to the quotient and holds the result item in
// an output register backed by a one-entry skid register.
// ----------------------------------------------------------------------------
module tpsc_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tpsc_pkg::div_item_t  item_i,
  output logic                 en_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tpsc_pkg::out_item_t  out_data_o
);
  import tpsc_pkg::*;

  out_item_t res_d;
  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_full_q;
  logic      take, arrive;

  always_comb begin
    res_d.status = STATUS_OK;
    res_d.value  = '0;
    if (item_i.err) begin
      res_d.status = STATUS_EQUAL;
    end else if (!item_i.neg) begin
      if (item_i.quo > NumW'(32767)) begin
        res_d.value  = 16'sd32767;
        res_d.status = STATUS_SAT;
      end else begin
        res_d.value = item_i.quo[15:0];
      end
    end else begin
      if (item_i.quo > NumW'(32768)) begin
        res_d.value  = -16'sd32768;
        res_d.status = STATUS_SAT;
      end else begin
        res_d.value = -item_i.quo[15:0];
      end
    end
  end

  assign en_o   = ~skid_full_q;
  assign take   = out_valid_q & ~out_stall_i;
  assign arrive = en_o & valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (take) begin
        skid_full_q <= 1'b0;
      end
    end else if (arrive) begin
      if (out_valid_q && !take) begin
        skid_full_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (arrive) begin
      if (out_valid_q && !take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_equal_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == STATUS_EQUAL |-> out_q.value == 16'sd0)
    else $error("equal reference raws must give a zero value");

  a_sat_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == STATUS_SAT |->
      out_q.value == 16'sd32767 || out_q.value == -16'sd32768)
    else $error("saturated item not at a range bound");

  a_skid_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q && !out_stall_i |=> !skid_full_q)
    else $error("skid register not drained after output taken");

endmodule

@@ rtl/two_point_sensor_calibration_unit.sv @@
// Path: an accepted input item passes through the front stages, the divider chain and the output
// register before its result item is valid at the output port.
// Throughput: one item per cycle while the input is not stalled; a 30-cell divider chain
// retires one quotient bit per cell. The output stall reaches the input through a one-entry
// skid register, so input stall rises in the cycle after an item arrives while the output is held.
// Reset (asynchronous, active low) clears all calibration registers to zero and
// empties the pipeline.
// ----------------------------------------------------------------------------
// two_point_sensor_calibration_unit
// Two-point linear calibration of humidity and temperature samples, scaled to
// 1/8 units (humidity) or 1/2 units (temperature) with truncation toward zero and 16-bit saturation.
// ----------------------------------------------------------------------------
module two_point_sensor_calibration_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tpsc_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tpsc_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tpsc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tpsc_pkg::CfgDatW-1:0]       cfg_data_i
);
  import tpsc_pkg::*;

  cal_regs_t regs_q;
  logic      en;

  assign cfg_ready_o = 1'b1;

  // Drop writes beyond the register list; keep only the low bits of each field.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HUM_LOW_REF:   regs_q.hum_low_ref   <= cfg_data_i[7:0];
        REG_HUM_HIGH_REF:  regs_q.hum_high_ref  <= cfg_data_i[7:0];
        REG_TEMP_LOW_REF:  regs_q.temp_low_ref  <= cfg_data_i[9:0];
        REG_TEMP_HIGH_REF: regs_q.temp_high_ref <= cfg_data_i[9:0];
        REG_HUM_LOW_RAW:   regs_q.hum_low_raw   <= cfg_data_i;
        REG_HUM_HIGH_RAW:  regs_q.hum_high_raw  <= cfg_data_i;
        REG_TEMP_LOW_RAW:  regs_q.temp_low_raw  <= cfg_data_i;
        REG_TEMP_HIGH_RAW: regs_q.temp_high_raw <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = ~en;

  logic      chain_valid [NumCells+1];
  div_item_t chain_item  [NumCells+1];

  tpsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .regs_i  (regs_q),
    .valid_o (chain_valid[0]),
    .item_o  (chain_item[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    tpsc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[k]),
      .item_i  (chain_item[k]),
      .valid_o (chain_valid[k+1]),
      .item_o  (chain_item[k+1])
    );
  end

  tpsc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[NumCells]),
    .item_i      (chain_item[NumCells]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain_valid[NumCells]) && $stable(chain_valid[0]))
    else $error("divider chain moved while stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 en |=> chain_valid[0])
    else $error("accepted item did not reach the divider chain");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == REG_HUM_LOW_RAW |=>
      regs_q.hum_low_raw == $past(cfg_data_i))
    else $error("configuration write lost");

endmodule

@@ verif/tb_two_point_sensor_calibration_unit.sv @@
// ----------------------------------------------------------------------------
// tb_two_point_sensor_calibration_unit
// Drives humidity and temperature samples through the calibration unit under
// several register settings, predicts each calibrated reading from its own
// copy of the calibration registers and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_two_point_sensor_calibration_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tpsc_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned RandomPerSet = 210;
  localparam logic [CfgIdxW-1:0] IdxPastList = 8'd8;
  localparam logic [CfgIdxW-1:0] IdxTop      = 8'hFF;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDatW-1:0]   cfg_data_i  = '0;

  two_point_sensor_calibration_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  cal_regs_t   cal_shadow = '0;
  in_item_t    pending_samples[$];
  out_item_t   expected_readings[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Calibrated reading: exact rational line value, truncated once, clamped to 16 bits
  function automatic out_item_t calibrate(in_item_t item);
    out_item_t res;
    longint x, x0, x1, y0, y1, scale, den, num, q;
    x = longint'($signed(item.raw_sample));
    if (item.mode == MODE_TEMP) begin
      y0 = longint'(cal_shadow.temp_low_ref);
      y1 = longint'(cal_shadow.temp_high_ref);
      x0 = longint'($signed(cal_shadow.temp_low_raw));
      x1 = longint'($signed(cal_shadow.temp_high_raw));
      scale = 2;
    end else begin
      y0 = longint'(cal_shadow.hum_low_ref);
      y1 = longint'(cal_shadow.hum_high_ref);
      x0 = longint'($signed(cal_shadow.hum_low_raw));
      x1 = longint'($signed(cal_shadow.hum_high_raw));
      scale = 8;
    end
    res.status = STATUS_OK;
    if (x1 == x0) begin
      res.value  = '0;
      res.status = STATUS_EQUAL;
    end else begin
      den = x1 - x0;
      num = (y0 * den + (x - x0) * (y1 - y0)) * scale;
      q   = num / den;
      if (q > 32767) begin
        q = 32767;
        res.status = STATUS_SAT;
      end else if (q < -32768) begin
        q = -32768;
        res.status = STATUS_SAT;
      end
      res.value = q[15:0];
    end
    return res;
  endfunction

  function automatic in_item_t sample_item(mode_e m, logic [15:0] raw);
    in_item_t item;
    item.mode       = m;
    item.raw_sample = raw;
    return item;
  endfunction

  task automatic write_cal_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HUM_LOW_REF:   cal_shadow.hum_low_ref   = data[7:0];
      REG_HUM_HIGH_REF:  cal_shadow.hum_high_ref  = data[7:0];
      REG_TEMP_LOW_REF:  cal_shadow.temp_low_ref  = data[9:0];
      REG_TEMP_HIGH_REF: cal_shadow.temp_high_ref = data[9:0];
      REG_HUM_LOW_RAW:   cal_shadow.hum_low_raw   = data;
      REG_HUM_HIGH_RAW:  cal_shadow.hum_high_raw  = data;
      REG_TEMP_LOW_RAW:  cal_shadow.temp_low_raw  = data;
      REG_TEMP_HIGH_RAW: cal_shadow.temp_high_raw = data;
      default: ;
    endcase
  endtask

  task automatic write_all_cal(logic [CfgDatW-1:0] hlo_ref, logic [CfgDatW-1:0] hhi_ref,
                               logic [CfgDatW-1:0] tlo_ref, logic [CfgDatW-1:0] thi_ref,
                               logic [CfgDatW-1:0] hlo_raw, logic [CfgDatW-1:0] hhi_raw,
                               logic [CfgDatW-1:0] tlo_raw, logic [CfgDatW-1:0] thi_raw);
    write_cal_reg(REG_HUM_LOW_REF,   hlo_ref);
    write_cal_reg(REG_HUM_HIGH_REF,  hhi_ref);
    write_cal_reg(REG_TEMP_LOW_REF,  tlo_ref);
    write_cal_reg(REG_TEMP_HIGH_REF, thi_ref);
    write_cal_reg(REG_HUM_LOW_RAW,   hlo_raw);
    write_cal_reg(REG_HUM_HIGH_RAW,  hhi_raw);
    write_cal_reg(REG_TEMP_LOW_RAW,  tlo_raw);
    write_cal_reg(REG_TEMP_HIGH_RAW, thi_raw);
  endtask

  task automatic randomize_cal();
    logic [CfgDatW-1:0] hlo_raw, hhi_raw, tlo_raw, thi_raw;
    hlo_raw = CfgDatW'($urandom);
    hhi_raw = CfgDatW'($urandom);
    tlo_raw = CfgDatW'($urandom);
    thi_raw = CfgDatW'($urandom);
    // steep lines push results into saturation, equal raws flag an error
    if ($urandom_range(3) == 0) hhi_raw = hlo_raw + CfgDatW'($urandom_range(1, 40));
    if ($urandom_range(3) == 0) thi_raw = tlo_raw - CfgDatW'($urandom_range(1, 40));
    if ($urandom_range(7) == 0) hhi_raw = hlo_raw;
    if ($urandom_range(7) == 0) thi_raw = tlo_raw;
    write_all_cal(CfgDatW'($urandom), CfgDatW'($urandom), CfgDatW'($urandom),
                  CfgDatW'($urandom), hlo_raw, hhi_raw, tlo_raw, thi_raw);
    write_cal_reg(CfgIdxW'($urandom_range(IdxPastList, IdxTop)), CfgDatW'($urandom));
  endtask

  task automatic push_random_samples(int unsigned count);
    mode_e       m;
    logic [15:0] raw;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(1) ? MODE_TEMP : MODE_HUM;
      if ($urandom_range(3) == 0) begin
        // land near a reference raw so the line is exercised in its useful span
        raw = (m == MODE_TEMP) ? cal_shadow.temp_low_raw : cal_shadow.hum_low_raw;
        if ($urandom_range(1)) raw = (m == MODE_TEMP) ? cal_shadow.temp_high_raw
                                                       : cal_shadow.hum_high_raw;
        raw = raw + 16'($urandom_range(0, 255)) - 16'd128;
      end else begin
        raw = 16'($urandom);
      end
      pending_samples.push_back(sample_item(m, raw));
    end
  endtask

  task automatic drain_readings();
    while (pending_samples.size() != 0 || expected_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sender: present the head of the queue, hold it until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_readings.push_back(calibrate(in_data_i));
        void'(pending_samples.pop_front());
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_samples[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted reading, stall at random or for a long hold
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reading: value %0d status %0d",
                     $signed(out_data_o.value), out_data_o.status);
        end else begin
          exp_item = expected_readings.pop_front();
          if (out_data_o.value !== exp_item.value || out_data_o.status !== exp_item.status)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                       $signed(exp_item.value), exp_item.status,
                       $signed(out_data_o.value), out_data_o.status);
          end
        end
      end
      if (hold_left == 0 && hold_served < hold_requests) begin
        hold_left = LongHold;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_two_point_sensor_calibration_unit NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at reset: both lines have equal raws; writes past the list change nothing
    write_cal_reg(IdxPastList, 16'h1234);
    write_cal_reg(IdxTop, 16'hFFFF);
    pending_samples.push_back(sample_item(MODE_HUM, 16'h1000));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h8000));
    drain_readings();

    // Ordinary lines, stray upper bits on the narrow refs, falling temperature line
    write_all_cal(16'hFF28, 16'hABA0, 16'hFC50, 16'h0590,
                  16'hFC18, 16'h0BB8, 16'h2EE0, 16'hEC78);
    pending_samples.push_back(sample_item(MODE_HUM, 16'h8000));
    pending_samples.push_back(sample_item(MODE_HUM, 16'h7FFF));
    pending_samples.push_back(sample_item(MODE_HUM, 16'h0000));
    pending_samples.push_back(sample_item(MODE_HUM, 16'hFFFF));
    pending_samples.push_back(sample_item(MODE_HUM, 16'hFC18));
    pending_samples.push_back(sample_item(MODE_HUM, 16'h0BB8));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h8000));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h7FFF));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h2EE0));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'hEC78));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h0000));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'hFFFF));
    drain_readings();

    // Extremes: steep humidity line saturates both ways, widest temperature span
    write_all_cal(16'h0000, 16'h00FF, 16'h03FF, 16'h0000,
                  16'h0000, 16'h0001, 16'h7FFF, 16'h8000);
    pending_samples.push_back(sample_item(MODE_HUM, 16'h7FFF));
    pending_samples.push_back(sample_item(MODE_HUM, 16'h8000));
    pending_samples.push_back(sample_item(MODE_HUM, 16'h0000));
    pending_samples.push_back(sample_item(MODE_HUM, 16'h0001));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h7FFF));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h8000));
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h0000));
    drain_readings();

    // Equal nonzero temperature raws
    write_cal_reg(REG_TEMP_LOW_RAW, 16'h8000);
    write_cal_reg(REG_TEMP_HIGH_RAW, 16'h8000);
    pending_samples.push_back(sample_item(MODE_TEMP, 16'h8000));
    pending_samples.push_back(sample_item(MODE_HUM, 16'h4000));
    drain_readings();

    for (int set = 0; set < 3; set++) begin
      case (set)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      randomize_cal();
      push_random_samples(RandomPerSet);
      // back up the output while the sender keeps offering items
      if (set == 2) hold_requests++;
      drain_readings();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_readings.size() == 0)
      $display("tb_two_point_sensor_calibration_unit OK");
    else
      $display("tb_two_point_sensor_calibration_unit NOT OK");
    $finish;
  end

endmodule
